FILE: hw/rtl/ddwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddwm_pkg: shared types and constants of the wheel mixer
// Command and result items, the divider item carried along the cell chain,
// and the mode codes.
// ----------------------------------------------------------------------------
package ddwm_pkg;

    localparam int TRACK_W = 12;
    localparam int DEN_W   = 21;  // 32 * radius
    localparam int REM_W   = 30;  // |speed| * (32R + T)
    localparam int QUO_W   = 15;  // quotient magnitude stays below 2^15
    localparam int DSH_W   = DEN_W + QUO_W - 1;

    // one cell per quotient bit
    localparam int DDWM_CELLS = QUO_W;
    // front stage, cell chain, output register
    localparam int LATENCY    = DDWM_CELLS + 2;

    localparam logic [1:0] MODE_STRAIGHT = 2'd0;
    localparam logic [1:0] MODE_SPIN     = 2'd1;
    localparam logic [1:0] MODE_ARC      = 2'd2;

    localparam logic signed [7:0] DUTY_MAX = 8'sd100;
    localparam logic signed [7:0] DUTY_MIN = -8'sd100;

    typedef struct packed {
        logic [1:0]        mode;
        logic signed [7:0] speed;
        logic [15:0]       radius;
        logic              turn_left;
    } t_cmd;

    typedef struct packed {
        logic signed [7:0] left_front;
        logic signed [7:0] left_rear;
        logic signed [7:0] right_front;
        logic signed [7:0] right_rear;
    } t_wheels;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             neg;
    } t_lane;

    typedef struct packed {
        logic              arc;
        logic              turn_left;
        logic signed [7:0] lval;
        logic signed [7:0] rval;
        logic [DSH_W-1:0]  dsh;
        t_lane             inner;
        t_lane             outer;
    } t_stage;

endpackage
`default_nettype wire

FILE: hw/rtl/diff_drive_wheel_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_wheel_mixer: four-wheel differential drive mixer
// Turns motion commands into left and right wheel duties.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a command on i_cmd; busy never rises, so a command is
//   taken in every cycle that start is high. Each item yields one result on
//   o_result, marked by o_valid for a single cycle. The command passes one
//   decode and multiply stage, a chain of 15 divider cells (one quotient
//   bit each, both sides in parallel) and an output register.
//   Throughput is one item per cycle.
//   The receiver cannot stall: results must be taken as they appear.
//   track_width is written over the APB port at byte address 0; the user
//   must write it only while no item is in flight; the block does not
//   enforce this. pready is always high. Reset clears the pipeline valid
//   bits and track_width to zero; items in flight at reset are dropped.
// ----------------------------------------------------------------------------
module diff_drive_wheel_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ddwm_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    output ddwm_pkg::t_wheels  o_result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ddwm_pkg::*;

    logic [TRACK_W-1:0] r_track;
    logic               cfg_wr;
    logic               chain_valid [DDWM_CELLS+1];
    t_stage             chain_stage [DDWM_CELLS+1];
    t_stage             last;
    logic signed [7:0]  inner_v;
    logic signed [7:0]  outer_v;
    logic               r_valid;
    t_wheels            r_result;
    t_wheels            n_result;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == 3'd0);
    assign prdata = (paddr == 3'd0) ? {{(32 - TRACK_W){1'b0}}, r_track} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= '0;
        end else if (cfg_wr) begin
            r_track <= pwdata[TRACK_W-1:0];
        end
    end

    ddwm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_cmd   (i_cmd),
        .i_track (r_track),
        .o_valid (chain_valid[0]),
        .o_stage (chain_stage[0])
    );

    for (genvar g = 0; g < DDWM_CELLS; g++) begin : g_cell
        ddwm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_stage (chain_stage[g]),
            .o_valid (chain_valid[g+1]),
            .o_stage (chain_stage[g+1])
        );
    end

    function automatic logic signed [7:0] to_duty(input t_lane lane);
        logic [6:0] mag;
        mag = (lane.quo > QUO_W'(100)) ? 7'd100 : lane.quo[6:0];
        return lane.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    always_comb begin
        last    = chain_stage[DDWM_CELLS];
        inner_v = to_duty(last.inner);
        outer_v = to_duty(last.outer);
        if (last.arc) begin
            // left side is the inner side on a left arc
            n_result.left_front  = last.turn_left ? inner_v : outer_v;
            n_result.right_front = last.turn_left ? outer_v : inner_v;
        end else begin
            n_result.left_front  = last.lval;
            n_result.right_front = last.rval;
        end
        n_result.left_rear  = n_result.left_front;
        n_result.right_rear = n_result.right_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= chain_valid[DDWM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a command at the expected latency");

    a_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.left_front == o_result.left_rear)
                 && (o_result.right_front == o_result.right_rear))
        else $error("wheel pair mismatch");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.left_front <= DUTY_MAX) && (o_result.left_front >= DUTY_MIN)
                 && (o_result.right_front <= DUTY_MAX) && (o_result.right_front >= DUTY_MIN))
        else $error("duty out of range");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_track == $past(pwdata[TRACK_W-1:0])))
        else $error("track width write lost");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/ddwm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddwm_front: command decode and numerator stage
// Works out the straight and spin duties, and for an arc the sign-magnitude
// numerators and the shifted divisor that enter the cell chain.
// ----------------------------------------------------------------------------
module ddwm_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  ddwm_pkg::t_cmd                i_cmd,
    input  logic [ddwm_pkg::TRACK_W-1:0]  i_track,
    output logic                          o_valid,
    output ddwm_pkg::t_stage              o_stage
);
    import ddwm_pkg::*;

    logic [15:0]       radius_1;
    logic [DEN_W-1:0]  den;
    logic [DEN_W:0]    f_out;
    logic [DEN_W-1:0]  f_in_mag;
    logic              f_in_neg;
    logic              v_neg;
    logic [7:0]        v_mag;
    logic [REM_W-1:0]  p_out;
    logic [REM_W-2:0]  p_in;
    logic signed [7:0] clamp_v;
    logic signed [7:0] spin_v;
    logic              r_valid;
    t_stage            r_stage;
    t_stage            n_stage;

    always_comb begin
        radius_1 = (i_cmd.radius == 16'd0) ? 16'd1 : i_cmd.radius;
        den      = {radius_1, 5'b0};
        f_out    = {1'b0, den} + {{(DEN_W + 1 - TRACK_W){1'b0}}, i_track};
        f_in_neg = (den < {{(DEN_W - TRACK_W){1'b0}}, i_track});
        if (f_in_neg) begin
            f_in_mag = {{(DEN_W - TRACK_W){1'b0}}, i_track} - den;
        end else begin
            f_in_mag = den - {{(DEN_W - TRACK_W){1'b0}}, i_track};
        end
        v_neg = i_cmd.speed[7];
        v_mag = v_neg ? 8'(-i_cmd.speed) : 8'(i_cmd.speed);
        p_out = {{(REM_W - 8){1'b0}}, v_mag} * {{(REM_W - DEN_W - 1){1'b0}}, f_out};
        p_in  = {{(REM_W - 9){1'b0}}, v_mag} * {{(REM_W - DEN_W - 1){1'b0}}, f_in_mag};

        if (i_cmd.speed > DUTY_MAX) begin
            clamp_v = DUTY_MAX;
        end else if (i_cmd.speed < DUTY_MIN) begin
            clamp_v = DUTY_MIN;
        end else begin
            clamp_v = i_cmd.speed;
        end
        // a reverse spin command becomes the slowest forward spin
        if (i_cmd.speed > DUTY_MAX) begin
            spin_v = DUTY_MAX;
        end else if (v_neg) begin
            spin_v = 8'sd1;
        end else begin
            spin_v = i_cmd.speed;
        end

        n_stage           = '0;
        n_stage.turn_left = i_cmd.turn_left;
        n_stage.dsh       = {den, {(QUO_W - 1){1'b0}}};
        n_stage.outer.rem = p_out;
        n_stage.outer.neg = v_neg;
        n_stage.inner.rem = {1'b0, p_in};
        n_stage.inner.neg = v_neg ^ f_in_neg;
        case (i_cmd.mode)
            MODE_STRAIGHT: begin
                n_stage.lval = clamp_v;
                n_stage.rval = clamp_v;
            end
            MODE_SPIN: begin
                n_stage.lval = i_cmd.turn_left ? -spin_v : spin_v;
                n_stage.rval = i_cmd.turn_left ? spin_v : -spin_v;
            end
            MODE_ARC: begin
                n_stage.arc = 1'b1;
            end
            default: begin
                n_stage.lval = 8'sd0;
                n_stage.rval = 8'sd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire

FILE: hw/rtl/ddwm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddwm_cell: one restoring divide step for both sides
// Settles one quotient bit of the inner and the outer lane, then halves the
// shifted divisor for the next cell.
// ----------------------------------------------------------------------------
module ddwm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ddwm_pkg::t_stage  i_stage,
    output logic              o_valid,
    output ddwm_pkg::t_stage  o_stage
);
    import ddwm_pkg::*;

    logic   r_valid;
    t_stage r_stage;
    t_stage n_stage;

    function automatic t_lane step(input t_lane lane, input logic [DSH_W-1:0] dsh);
        logic [DSH_W-1:0] rem_x;
        logic             fit;
        t_lane            res;
        rem_x   = {{(DSH_W - REM_W){1'b0}}, lane.rem};
        fit     = (rem_x >= dsh);
        res     = lane;
        res.quo = {lane.quo[QUO_W-2:0], fit};
        if (fit) begin
            res.rem = REM_W'(rem_x - dsh);
        end
        return res;
    endfunction

    always_comb begin
        n_stage       = i_stage;
        n_stage.inner = step(i_stage.inner, i_stage.dsh);
        n_stage.outer = step(i_stage.outer, i_stage.dsh);
        n_stage.dsh   = i_stage.dsh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule
`default_nettype wire
